FILE: rtl/ius_pkg.sv
// Shared types and constants for the integer pixel upscaler.
`timescale 1ns / 1ps

package ius_pkg;

	localparam int unsigned SCALE_W  = 7;
	localparam int unsigned DIM_W    = 13;
	localparam int unsigned ROW_W    = 12;
	localparam int unsigned PIX_W    = 24;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [SCALE_W-1:0] MAX_SCALE  = 7'd100;
	localparam logic [DIM_W-1:0]   MAX_HEIGHT = 13'd4096;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_TICK  = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE  = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} cfg_reg_t;

	// One result as decided at accept time; from_buf selects the line buffer pixel.
	typedef struct packed {
		logic               valid;
		logic               from_buf;
		logic [PIX_W-1:0]   pixel;
		logic [SCALE_W-1:0] repeat_count;
		logic               row_end;
		logic [1:0]         pad_bytes;
		logic               image_end;
		logic               error;
	} res_t;

endpackage

FILE: rtl/ius_line_buf.sv
// Line buffer: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module ius_line_buf #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW    = 12
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [ius_pkg::PIX_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [ius_pkg::PIX_W-1:0] rd_data
);

	logic [ius_pkg::PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/ius_ctrl.sv
// Configuration registers, row and replay counters, and per-word result decode.
`timescale 1ns / 1ps

module ius_ctrl #(
	parameter int unsigned MAX_WIDTH = 4096,
	parameter int unsigned AW        = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ius_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ius_pkg::DIM_W-1:0]     cfg_data,
	input  logic                          accept,
	input  logic                          op,
	input  logic [ius_pkg::PIX_W-1:0]     pixel,
	output logic                          wr_en,
	output logic [AW-1:0]                 wr_addr,
	output logic                          rd_en,
	output logic [AW-1:0]                 rd_addr,
	output ius_pkg::res_t                 res
);

	localparam int unsigned EW = (AW + 1 > ius_pkg::DIM_W) ? AW + 1 : ius_pkg::DIM_W;
	localparam logic [EW-1:0] MAX_W_E = EW'(MAX_WIDTH);

	logic [ius_pkg::SCALE_W-1:0] scale_q;
	logic [ius_pkg::DIM_W-1:0]   width_q;
	logic [ius_pkg::DIM_W-1:0]   height_q;
	logic [AW-1:0]               column_q, column_d;
	logic [AW-1:0]               replay_col_q, replay_col_d;
	logic [ius_pkg::ROW_W-1:0]   row_q, row_d;
	logic [ius_pkg::SCALE_W-1:0] replays_q, replays_d;

	logic [ius_pkg::SCALE_W-1:0] eff_scale;
	logic [EW-1:0]               width_e, eff_width, width_last;
	logic [ius_pkg::DIM_W-1:0]   eff_height, height_last;
	logic                        last_row;
	logic                        pix_end, tick_end;
	logic [4:0]                  pad_prod;
	logic [1:0]                  pad;
	logic                        is_tick, busy;
	logic [ius_pkg::ROW_W-1:0]   row_next;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= ius_pkg::SCALE_W'(1);
			width_q  <= ius_pkg::DIM_W'(1);
			height_q <= ius_pkg::DIM_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ius_pkg::REG_SCALE:  scale_q  <= cfg_data[ius_pkg::SCALE_W-1:0];
				ius_pkg::REG_WIDTH:  width_q  <= cfg_data;
				ius_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp the configuration into its working range.
	always_comb begin
		if (scale_q == '0)                  eff_scale = ius_pkg::SCALE_W'(1);
		else if (scale_q > ius_pkg::MAX_SCALE) eff_scale = ius_pkg::MAX_SCALE;
		else                                eff_scale = scale_q;

		width_e = EW'(width_q);
		if (width_e == '0)          eff_width = EW'(1);
		else if (width_e > MAX_W_E) eff_width = MAX_W_E;
		else                        eff_width = width_e;

		if (height_q == '0)                    eff_height = ius_pkg::DIM_W'(1);
		else if (height_q > ius_pkg::MAX_HEIGHT) eff_height = ius_pkg::MAX_HEIGHT;
		else                                   eff_height = height_q;
	end

	assign width_last  = eff_width - EW'(1);
	assign height_last = eff_height - ius_pkg::DIM_W'(1);
	assign last_row    = {1'b0, row_q} >= height_last;
	assign pix_end     = EW'(column_q) >= width_last;
	assign tick_end    = EW'(replay_col_q) >= width_last;
	assign row_next    = last_row ? '0 : row_q + ius_pkg::ROW_W'(1);

	// Row bytes are 3*w*s; only the low two bits of w and s matter.
	assign pad_prod = 5'd3 * {3'd0, eff_width[1:0]} * {3'd0, eff_scale[1:0]};
	assign pad      = 2'd0 - pad_prod[1:0];

	assign is_tick = (op == ius_pkg::OP_TICK);
	assign busy    = (replays_q != '0);

	always_comb begin
		column_d     = column_q;
		replay_col_d = replay_col_q;
		row_d        = row_q;
		replays_d    = replays_q;
		wr_en        = 1'b0;
		rd_en        = 1'b0;
		res          = '0;
		res.pixel    = pixel;

		if (!is_tick) begin
			if (busy) begin
				// refuse the pixel, leave state alone
				res.valid = 1'b1;
				res.pixel = '0;
				res.error = 1'b1;
			end else begin
				wr_en            = accept;
				res.valid        = 1'b1;
				res.repeat_count = eff_scale;
				res.row_end      = pix_end;
				res.pad_bytes    = pix_end ? pad : 2'd0;
				res.image_end    = pix_end && last_row && (eff_scale == ius_pkg::SCALE_W'(1));
				if (pix_end) begin
					column_d     = '0;
					replay_col_d = '0;
					replays_d    = eff_scale - ius_pkg::SCALE_W'(1);
					if (eff_scale == ius_pkg::SCALE_W'(1)) begin
						row_d = row_next;
					end
				end else begin
					column_d = column_q + AW'(1);
				end
			end
		end else if (busy) begin
			rd_en            = accept;
			res.valid        = 1'b1;
			res.from_buf     = 1'b1;
			res.repeat_count = eff_scale;
			res.row_end      = tick_end;
			res.pad_bytes    = tick_end ? pad : 2'd0;
			res.image_end    = tick_end && (replays_q == ius_pkg::SCALE_W'(1)) && last_row;
			if (tick_end) begin
				replay_col_d = '0;
				replays_d    = replays_q - ius_pkg::SCALE_W'(1);
				if (replays_q == ius_pkg::SCALE_W'(1)) begin
					row_d = row_next;
				end
			end else begin
				replay_col_d = replay_col_q + AW'(1);
			end
		end
	end

	assign wr_addr = column_q;
	assign rd_addr = replay_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q     <= '0;
			replay_col_q <= '0;
			row_q        <= '0;
			replays_q    <= '0;
		end else if (accept) begin
			column_q     <= column_d;
			replay_col_q <= replay_col_d;
			row_q        <= row_d;
			replays_q    <= replays_d;
		end
	end

endmodule

FILE: rtl/integer_pixel_upscaler.sv
// A taken word passes the decode stage, then the output register (an idle tick gives none).
// Throughput: one word per cycle when in_ready; a word makes at most one buffer write or read.
// The decode stage and the output register each hold one word, so input stays ready under stall
// as long as either has room.
// Reset clears counters and sets scale, width and height to 1; line buffer contents are
// undefined until written and get no clearing pass.
`timescale 1ns / 1ps

module integer_pixel_upscaler #(
	parameter int unsigned MAX_WIDTH = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ius_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ius_pkg::DIM_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          op,
	input  logic [7:0]                    blue,
	input  logic [7:0]                    green,
	input  logic [7:0]                    red,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    out_blue,
	output logic [7:0]                    out_green,
	output logic [7:0]                    out_red,
	output logic [ius_pkg::SCALE_W-1:0]   repeat_count,
	output logic                          row_end,
	output logic [1:0]                    pad_bytes,
	output logic                          image_end,
	output logic                          error
);

	localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic                      accept;
	logic                      wr_en, rd_en;
	logic [AW-1:0]             wr_addr, rd_addr;
	logic [ius_pkg::PIX_W-1:0] in_pixel, rd_data;
	ius_pkg::res_t             res, res_s1, res_s2;
	logic                      valid_s1, valid_s2;
	logic                      load_s2;

	assign in_pixel = {red, green, blue};
	assign load_s2  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || load_s2;
	assign accept   = in_valid && in_ready;

	ius_ctrl #(
		.MAX_WIDTH(MAX_WIDTH),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.accept(accept),
		.op(op),
		.pixel(in_pixel),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.res(res)
	);

	ius_line_buf #(
		.DEPTH(MAX_WIDTH),
		.AW(AW)
	) u_line_buf (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(in_pixel),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= res.valid;
		end else if (load_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// Replayed words take their pixel from the buffer read register.
	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			res_s2 <= res_s1;
			if (res_s1.from_buf) begin
				res_s2.pixel <= rd_data;
			end
		end
	end

	assign out_valid    = valid_s2;
	assign out_blue     = res_s2.pixel[7:0];
	assign out_green    = res_s2.pixel[15:8];
	assign out_red      = res_s2.pixel[23:16];
	assign repeat_count = res_s2.repeat_count;
	assign row_end      = res_s2.row_end;
	assign pad_bytes    = res_s2.pad_bytes;
	assign image_end    = res_s2.image_end;
	assign error        = res_s2.error;

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2)
		else $error("input stalled with free pipeline room");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> repeat_count == '0 && !row_end && !image_end
			&& pad_bytes == 2'd0 && out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0)
		else $error("error word carries nonzero fields");

	a_repeat_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !error |-> repeat_count != '0 && repeat_count <= ius_pkg::MAX_SCALE)
		else $error("repeat count out of range");

	a_image_end_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_end |-> row_end)
		else $error("image end without row end");

	a_pad_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !row_end |-> pad_bytes == 2'd0)
		else $error("padding outside row end");

endmodule

FILE: dv/tb_integer_pixel_upscaler.sv
// Testbench for the integer pixel upscaler: run predictor, scoreboard, drivers and test sequence.
`timescale 1ns / 1ps

typedef struct packed {
	logic [7:0] blue;
	logic [7:0] green;
	logic [7:0] red;
	logic [6:0] repeat_count;
	logic       row_end;
	logic [1:0] pad_bytes;
	logic       image_end;
	logic       error;
} pixel_run_t;

class upscale_scoreboard;
	int unsigned line_depth;
	logic [23:0] line_buf[];
	int unsigned column_count;
	int unsigned row_count;
	int unsigned replays_left;
	int unsigned replay_column;
	logic [6:0]  scale_reg;
	logic [12:0] width_reg;
	logic [12:0] height_reg;
	pixel_run_t  expected_runs[$];
	int unsigned mismatches;
	int unsigned runs_checked;
	int unsigned refused_pixels;
	int unsigned images_done;
	logic [3:0]  pads_seen;

	function new(int unsigned depth);
		line_depth = depth;
		line_buf = new[depth];
		column_count = 0;
		row_count = 0;
		replays_left = 0;
		replay_column = 0;
		scale_reg = 7'd1;
		width_reg = 13'd1;
		height_reg = 13'd1;
		mismatches = 0;
		runs_checked = 0;
		refused_pixels = 0;
		images_done = 0;
		pads_seen = '0;
	endfunction

	function int unsigned scale_in_use();
		if (scale_reg == 0)
			return 1;
		return (scale_reg > ius_pkg::MAX_SCALE) ? ius_pkg::MAX_SCALE : scale_reg;
	endfunction

	function int unsigned width_in_use();
		if (width_reg == 0)
			return 1;
		return (width_reg > line_depth) ? line_depth : width_reg;
	endfunction

	function int unsigned height_in_use();
		if (height_reg == 0)
			return 1;
		return (height_reg > ius_pkg::MAX_HEIGHT) ? ius_pkg::MAX_HEIGHT : height_reg;
	endfunction

	function void write_reg(ius_pkg::cfg_reg_t idx, logic [12:0] data);
		case (idx)
			ius_pkg::REG_SCALE:  scale_reg = data[6:0];
			ius_pkg::REG_WIDTH:  width_reg = data;
			ius_pkg::REG_HEIGHT: height_reg = data;
			default: ;
		endcase
	endfunction

	function pixel_run_t make_run(logic [23:0] pix, bit rend, bit iend);
		pixel_run_t run;
		int unsigned m;
		run = '0;
		run.blue = pix[7:0];
		run.green = pix[15:8];
		run.red = pix[23:16];
		run.repeat_count = 7'(scale_in_use());
		run.row_end = rend;
		// BMP rows are padded to a multiple of four bytes
		m = (3 * width_in_use() * scale_in_use()) & 3;
		run.pad_bytes = rend ? 2'((4 - m) & 3) : 2'd0;
		run.image_end = iend;
		return run;
	endfunction

	function void next_row();
		if (row_count >= height_in_use() - 1)
			row_count = 0;
		else
			row_count++;
	endfunction

	// Returns 1 when the word produces an output run.
	function bit note_word(ius_pkg::op_t op, logic [7:0] blue, logic [7:0] green,
			logic [7:0] red);
		int unsigned w;
		bit last_row;
		bit rend;
		bit iend;
		logic [23:0] pix;
		pixel_run_t run;
		w = width_in_use();
		last_row = row_count >= height_in_use() - 1;
		if (op == ius_pkg::OP_PIXEL) begin
			if (replays_left != 0) begin
				run = '0;
				run.error = 1'b1;
				expected_runs.push_back(run);
				return 1'b1;
			end
			pix = {red, green, blue};
			line_buf[column_count % line_depth] = pix;
			rend = column_count >= w - 1;
			iend = rend && last_row && scale_in_use() == 1;
			expected_runs.push_back(make_run(pix, rend, iend));
			if (rend) begin
				column_count = 0;
				replay_column = 0;
				replays_left = scale_in_use() - 1;
				if (replays_left == 0)
					next_row();
			end else begin
				column_count++;
			end
			return 1'b1;
		end
		if (replays_left == 0)
			return 1'b0;
		pix = line_buf[replay_column % line_depth];
		rend = replay_column >= w - 1;
		iend = rend && replays_left == 1 && last_row;
		expected_runs.push_back(make_run(pix, rend, iend));
		if (rend) begin
			replay_column = 0;
			replays_left--;
			if (replays_left == 0)
				next_row();
		end else begin
			replay_column++;
		end
		return 1'b1;
	endfunction

	task report_mismatch(string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task compare_field(string name, logic [7:0] got_v, logic [7:0] want_v);
		if (got_v !== want_v)
			report_mismatch($sformatf("run %0d %s got %h want %h", runs_checked, name,
				got_v, want_v));
	endtask

	task check_run(pixel_run_t got);
		pixel_run_t want;
		if (expected_runs.size() == 0) begin
			report_mismatch($sformatf("output word %h with nothing pending", got));
			return;
		end
		want = expected_runs.pop_front();
		runs_checked++;
		if (want.error)
			refused_pixels++;
		if (want.row_end)
			pads_seen[want.pad_bytes] = 1'b1;
		if (want.image_end)
			images_done++;
		compare_field("out_blue", got.blue, want.blue);
		compare_field("out_green", got.green, want.green);
		compare_field("out_red", got.red, want.red);
		compare_field("repeat_count", 8'(got.repeat_count), 8'(want.repeat_count));
		compare_field("row_end", 8'(got.row_end), 8'(want.row_end));
		compare_field("pad_bytes", 8'(got.pad_bytes), 8'(want.pad_bytes));
		compare_field("image_end", 8'(got.image_end), 8'(want.image_end));
		compare_field("error", 8'(got.error), 8'(want.error));
	endtask
endclass

module tb_integer_pixel_upscaler;

	localparam int unsigned LINE_DEPTH = 4096;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned PRESSURE_AT = 100;
	localparam int unsigned PRESSURE_CYCLES = 150;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	ius_pkg::cfg_reg_t             cfg_index = ius_pkg::REG_SCALE;
	logic [ius_pkg::DIM_W-1:0]     cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	ius_pkg::op_t                  op = ius_pkg::OP_PIXEL;
	logic [7:0]                    blue = '0;
	logic [7:0]                    green = '0;
	logic [7:0]                    red = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [7:0]                    out_blue;
	logic [7:0]                    out_green;
	logic [7:0]                    out_red;
	logic [ius_pkg::SCALE_W-1:0]   repeat_count;
	logic                          row_end;
	logic [1:0]                    pad_bytes;
	logic                          image_end;
	logic                          error;

	upscale_scoreboard sb = new(LINE_DEPTH);
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned words_in = 0;
	int unsigned answered_words = 0;
	int unsigned reg_writes = 0;
	int unsigned hold_left = 0;
	bit          pressure_done = 1'b0;
	int unsigned quiet_cycles = 0;

	integer_pixel_upscaler #(.MAX_WIDTH(LINE_DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .op(op),
		.blue(blue), .green(green), .red(red),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_blue(out_blue), .out_green(out_green), .out_red(out_red),
		.repeat_count(repeat_count), .row_end(row_end), .pad_bytes(pad_bytes),
		.image_end(image_end), .error(error)
	);

	always #1 clk = ~clk;

	// Output side: random stalls, plus one long hold-off that backs up the input.
	always @(posedge clk) begin
		if (!pressure_done && words_in >= PRESSURE_AT) begin
			hold_left = PRESSURE_CYCLES;
			pressure_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_run({out_blue, out_green, out_red, repeat_count, row_end, pad_bytes,
				image_end, error});
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic program_reg(ius_pkg::cfg_reg_t idx, int unsigned value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= ius_pkg::DIM_W'(value);
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, ius_pkg::DIM_W'(value));
		reg_writes++;
		cfg_valid <= 1'b0;
	endtask

	task automatic send_word(ius_pkg::op_t word_op, logic [7:0] b, logic [7:0] g,
			logic [7:0] r);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		op <= word_op;
		blue <= b;
		green <= g;
		red <= r;
		do @(posedge clk); while (!in_ready);
		words_in++;
		if (sb.note_word(word_op, b, g, r))
			answered_words++;
	endtask

	// Drop valid and wait until every pending run is out and the pipeline is empty.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.expected_runs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mostly follow the row protocol; now and then send the wrong kind of word.
	task automatic send_random_word();
		bit pending;
		bit noise;
		pending = sb.replays_left != 0;
		noise = $urandom_range(99) < 8;
		if (pending != noise)
			send_word(ius_pkg::OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
		else
			send_word(ius_pkg::OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic reconfigure();
		int unsigned pick;
		int unsigned cur;
		pick = $urandom_range(99);
		if (pick < 4) begin
			// keep the huge replay count affordable: one-pixel rows, unless the width write below widens them
			program_reg(ius_pkg::REG_SCALE, 100);
			program_reg(ius_pkg::REG_WIDTH, 1);
		end else if (pick < 50) begin
			program_reg(ius_pkg::REG_SCALE, (pick < 8) ? 0 : $urandom_range(1, 6));
		end
		if ($urandom_range(1) == 1) begin
			cur = sb.width_in_use();
			pick = $urandom_range(99);
			// never widen while a row replays: that would read columns never written
			if (sb.replays_left != 0)
				program_reg(ius_pkg::REG_WIDTH, $urandom_range(1, (cur > 8) ? 8 : cur));
			else
				program_reg(ius_pkg::REG_WIDTH,
					(pick < 4) ? 0 : (pick < 7) ? 24 : $urandom_range(1, 8));
		end
		if ($urandom_range(1) == 1)
			program_reg(ius_pkg::REG_HEIGHT,
				($urandom_range(99) < 5) ? 0 : $urandom_range(1, 4));
	endtask

	initial begin
		int unsigned target;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: scale 1, one pixel per row, one row per image.
		send_word(ius_pkg::OP_TICK, 8'hFF, 8'hFF, 8'hFF);
		send_word(ius_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00);
		settle();

		program_reg(ius_pkg::REG_SCALE, 3);
		program_reg(ius_pkg::REG_WIDTH, 2);
		program_reg(ius_pkg::REG_HEIGHT, 2);
		repeat (2) begin
			send_word(ius_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
			send_word(ius_pkg::OP_PIXEL, 8'hA5, 8'h5A, 8'hC3);
			send_word(ius_pkg::OP_PIXEL, 8'h77, 8'h77, 8'h77);
			repeat (4) send_word(ius_pkg::OP_TICK, 8'h00, 8'h00, 8'h00);
		end
		settle();

		// Out-of-range values clamp; then narrow the row and the image mid-way.
		program_reg(ius_pkg::REG_SCALE, 0);
		program_reg(ius_pkg::REG_WIDTH, 8191);
		program_reg(ius_pkg::REG_HEIGHT, 8191);
		repeat (3) send_word(ius_pkg::OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
		settle();
		program_reg(ius_pkg::REG_WIDTH, 2);
		send_word(ius_pkg::OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
		settle();
		program_reg(ius_pkg::REG_HEIGHT, 0);
		repeat (2) send_word(ius_pkg::OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
		settle();
		program_reg(ius_pkg::REG_SCALE, 127);
		program_reg(ius_pkg::REG_WIDTH, 1);
		send_word(ius_pkg::OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
		repeat (2) send_word(ius_pkg::OP_TICK, 8'h00, 8'h00, 8'h00);
		settle();
		// pending replays keep their count but carry the new repeat count
		program_reg(ius_pkg::REG_SCALE, 5);
		repeat (2) send_word(ius_pkg::OP_TICK, 8'h00, 8'h00, 8'h00);

		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle_pct = 17;
					recv_idle_pct = 67;
				end
				1: begin
					send_idle_pct = 67;
					recv_idle_pct = 17;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int phase = 0; phase < 5; phase++) begin
				settle();
				reconfigure();
				target = answered_words + $urandom_range(20, 40);
				while (answered_words < target)
					send_random_word();
			end
		end
		settle();

		$display("Run covered %0d input words (%0d answered), %0d register writes",
			words_in, answered_words, reg_writes);
		$display("Runs checked %0d, refused pixels %0d, image ends %0d, padding seen %b",
			sb.runs_checked, sb.refused_pixels, sb.images_done, sb.pads_seen);
		if (sb.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
